// ===== src/dhnt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhnt_pkg
// Shared types, sizes and codes for the double-hashed name table.
// ----------------------------------------------------------------------------
package dhnt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int NAME_BYTES  = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int NAME_W   = 64;
    localparam int CFG_W    = 8;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int IDX_W  = $clog2(TABLE_DEPTH);          // slot address
    localparam int SZ_W   = $clog2(TABLE_DEPTH + 1);      // table size / probe count
    localparam int U_W    = SZ_W + 1;                     // compare-subtract operand
    localparam int KEY_W  = $clog2(255 * NAME_BYTES + 1); // byte sum
    localparam int BIT_W  = $clog2(KEY_W);                // key bit pointer
    localparam int ENTRY_W = STATUS_W + NAME_W;           // RAM word

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(127);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_GONE  = 2'd2
    } slot_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MODA,
        S_MODB,
        S_PRIME,
        S_PROBE
    } state_t;

endpackage

// ===== src/dhnt_ram.sv =====
// ----------------------------------------------------------------------------
// dhnt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dhnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/dhnt_csub.sv =====
// ----------------------------------------------------------------------------
// dhnt_csub
// Compare-and-subtract: one restoring division step or one modular add fold.
// ----------------------------------------------------------------------------
module dhnt_csub (
    input  logic [dhnt_pkg::U_W-1:0] a,
    input  logic [dhnt_pkg::U_W-1:0] b,
    output logic [dhnt_pkg::U_W-1:0] y
);

    // drop b once when a has reached it
    assign y = (a >= b) ? (a - b) : a;

endmodule

// ===== src/double_hash_name_table.sv =====
// ----------------------------------------------------------------------------
// double_hash_name_table
// Open-addressed name table with double hashing and tombstones.
// ----------------------------------------------------------------------------
// Usage
//   Command beat: raise start with op (0 insert, 1 search, 2 remove) and
//   name_bytes; the beat is taken on a clock edge where busy is low. busy
//   stays high until the result beat has been produced.
//   Result beat: done pulses for one cycle with success and slot_index. The
//   receiver cannot hold it off; it must capture the beat in that cycle.
//   Configuration: cfg_wr_en with cfg_wr_data writes table_size; write only
//   while busy is low and no result is outstanding.
// Timing
//   One key bit per cycle through a single shared compare-subtract unit, for
//   each of the two hash moduli in turn, then one slot per cycle from the
//   name RAM, probing at least one slot and at most every slot of the
//   clamped table size.
//   An unused op code skips hashing and probing and answers from the sum state.
//   One command at a time; busy goes low in the cycle done pulses.
// Reset
//   All slots read as empty (per-slot valid flags cleared), table_size = 127,
//   sequencer idle. The name RAM itself is not cleared.
// ----------------------------------------------------------------------------
module double_hash_name_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dhnt_pkg::OP_W-1:0]        op,
    input  logic [dhnt_pkg::NAME_W-1:0]      name_bytes,
    input  logic                             cfg_wr_en,
    input  logic [dhnt_pkg::CFG_W-1:0]       cfg_wr_data,
    output logic                             done,
    output logic                             success,
    output logic [dhnt_pkg::SLOT_W-1:0]      slot_index
);

    localparam int IDX_W  = dhnt_pkg::IDX_W;
    localparam int SZ_W   = dhnt_pkg::SZ_W;
    localparam int U_W    = dhnt_pkg::U_W;
    localparam int KEY_W  = dhnt_pkg::KEY_W;
    localparam int BIT_W  = dhnt_pkg::BIT_W;
    localparam int NAME_W = dhnt_pkg::NAME_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    dhnt_pkg::state_t              state_reg, state_next;
    logic [dhnt_pkg::CFG_W-1:0]    table_size_reg;
    logic [dhnt_pkg::OP_W-1:0]     op_reg, op_next;
    logic [NAME_W-1:0]             name_reg, name_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [SZ_W-1:0]               m_reg, m_next;
    logic [SZ_W-1:0]               rem_reg, rem_next;
    logic [BIT_W-1:0]              bit_reg, bit_next;
    logic [IDX_W-1:0]              j_reg, j_next;
    logic [IDX_W-1:0]              step_reg, step_next;
    logic [SZ_W-1:0]               i_reg, i_next;
    logic                          done_reg, done_next;
    logic                          success_reg, success_next;
    logic [dhnt_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [dhnt_pkg::TABLE_DEPTH-1:0] valid_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [NAME_W-1:0]             canon_name;
    logic [KEY_W-1:0]              key_sum;
    logic [SZ_W-1:0]               eff_size;
    logic [U_W-1:0]                unit_a, unit_b, unit_y;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_raddr;
    logic [dhnt_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
    dhnt_pkg::slot_status_t        rd_status;
    dhnt_pkg::slot_status_t        wr_status;
    logic [NAME_W-1:0]             rd_name;

    // Canonical name: keep the low NAME_BYTES bytes, zero from the first nul on
    always_comb
    begin
        logic seen_nul;
        seen_nul   = 1'b0;
        canon_name = '0;
        for (int b = 0; b < dhnt_pkg::NAME_BYTES; b++)
        begin
            if (name_bytes[8*b +: 8] == 8'd0)
            begin
                seen_nul = 1'b1;
            end
            if (!seen_nul)
            begin
                canon_name[8*b +: 8] = name_bytes[8*b +: 8];
            end
        end
    end

    // Byte sum of the held canonical name
    always_comb
    begin
        key_sum = '0;
        for (int b = 0; b < dhnt_pkg::NAME_BYTES; b++)
        begin
            key_sum = key_sum + KEY_W'(name_reg[8*b +: 8]);
        end
    end

    // Effective table size, clamped to [2, TABLE_DEPTH]
    always_comb
    begin
        int sz;
        sz = int'(table_size_reg);
        if (sz < 2)
        begin
            sz = 2;
        end
        if (sz > dhnt_pkg::TABLE_DEPTH)
        begin
            sz = dhnt_pkg::TABLE_DEPTH;
        end
        eff_size = SZ_W'(sz);
    end

    // Shared compare-subtract unit
    dhnt_csub u_csub (
        .a (unit_a),
        .b (unit_b),
        .y (unit_y)
    );

    // Entry store: {status, name} per slot
    dhnt_ram #(
        .WIDTH (dhnt_pkg::ENTRY_W),
        .DEPTH (dhnt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (j_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // A slot never written since reset reads as empty
    assign rd_status = valid_reg[j_reg]
                     ? dhnt_pkg::slot_status_t'(ram_rdata[NAME_W +: dhnt_pkg::STATUS_W])
                     : dhnt_pkg::SLOT_EMPTY;
    assign rd_name   = ram_rdata[NAME_W-1:0];
    assign ram_wdata = {wr_status, name_reg};

    // ------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhnt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= dhnt_pkg::TABLE_SIZE_RST;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                valid_reg[j_reg] <= 1'b1;
            end
            done_reg <= done_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        name_reg    <= name_next;
        key_reg     <= key_next;
        m_reg       <= m_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        j_reg       <= j_next;
        step_reg    <= step_next;
        i_reg       <= i_next;
        success_reg <= success_next;
        slot_reg    <= slot_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        logic finish;
        logic ok;

        state_next   = state_reg;
        op_next      = op_reg;
        name_next    = name_reg;
        key_next     = key_reg;
        m_next       = m_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        j_next       = j_reg;
        step_next    = step_reg;
        i_next       = i_reg;
        done_next    = 1'b0;
        success_next = success_reg;
        slot_next    = slot_reg;
        ram_we       = 1'b0;
        ram_raddr    = j_reg;
        wr_status    = dhnt_pkg::SLOT_USED;
        unit_a       = {rem_reg, key_reg[bit_reg]};
        unit_b       = U_W'(m_reg);
        finish       = 1'b0;
        ok           = 1'b0;

        case (state_reg)
            dhnt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    name_next  = canon_name;
                    m_next     = eff_size;
                    state_next = dhnt_pkg::S_SUM;
                end
            end

            dhnt_pkg::S_SUM:
            begin
                key_next = key_sum;
                rem_next = '0;
                bit_next = BIT_W'(KEY_W - 1);
                if (op_reg == dhnt_pkg::OP_INSERT || op_reg == dhnt_pkg::OP_SEARCH ||
                    op_reg == dhnt_pkg::OP_REMOVE)
                begin
                    state_next = dhnt_pkg::S_MODA;
                end
                else
                begin
                    // unused op code: report failure, touch nothing
                    finish = 1'b1;
                end
            end

            // key mod m, one key bit a cycle
            dhnt_pkg::S_MODA:
            begin
                unit_b   = U_W'(m_reg);
                rem_next = SZ_W'(unit_y);
                if (bit_reg == '0)
                begin
                    j_next     = IDX_W'(unit_y);
                    rem_next   = '0;
                    bit_next   = BIT_W'(KEY_W - 1);
                    state_next = dhnt_pkg::S_MODB;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            // key mod (m - 1), plus one, gives the probe stride
            dhnt_pkg::S_MODB:
            begin
                unit_b   = U_W'(m_reg - 1'b1);
                rem_next = SZ_W'(unit_y);
                if (bit_reg == '0)
                begin
                    step_next  = IDX_W'(unit_y + U_W'(1));
                    i_next     = '0;
                    state_next = dhnt_pkg::S_PRIME;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            // issue the read of the first probed slot
            dhnt_pkg::S_PRIME:
            begin
                ram_raddr  = j_reg;
                state_next = dhnt_pkg::S_PROBE;
            end

            // one slot a cycle: judge slot j, fetch the next one
            dhnt_pkg::S_PROBE:
            begin
                unit_a = U_W'(j_reg) + U_W'(step_reg);
                unit_b = U_W'(m_reg);
                case (op_reg)
                    dhnt_pkg::OP_INSERT:
                    begin
                        if (rd_status != dhnt_pkg::SLOT_USED)
                        begin
                            ram_we = 1'b1;
                            finish = 1'b1;
                            ok     = 1'b1;
                        end
                    end
                    dhnt_pkg::OP_SEARCH, dhnt_pkg::OP_REMOVE:
                    begin
                        if (rd_status == dhnt_pkg::SLOT_USED && rd_name == name_reg)
                        begin
                            finish = 1'b1;
                            ok     = 1'b1;
                            if (op_reg == dhnt_pkg::OP_REMOVE)
                            begin
                                ram_we    = 1'b1;
                                wr_status = dhnt_pkg::SLOT_GONE;
                            end
                        end
                        else if (rd_status == dhnt_pkg::SLOT_EMPTY)
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                if (!finish)
                begin
                    if ((i_reg + SZ_W'(1)) == m_reg)
                    begin
                        // every slot probed
                        finish = 1'b1;
                    end
                    else
                    begin
                        i_next    = i_reg + SZ_W'(1);
                        j_next    = IDX_W'(unit_y);
                        ram_raddr = IDX_W'(unit_y);
                    end
                end
            end

            default:
            begin
                state_next = dhnt_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next    = 1'b1;
            success_next = ok;
            slot_next    = ok ? dhnt_pkg::SLOT_W'(j_reg) : '0;
            state_next   = dhnt_pkg::S_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy       = (state_reg != dhnt_pkg::S_IDLE);
    assign done       = done_reg;
    assign success    = success_reg;
    assign slot_index = slot_reg;

endmodule

// ===== test/double_hash_name_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_hash_name_table_tb
// Self-checking bench for the double-hashed name table. A directed opening
// covers the reset size, colliding names, tombstones, duplicates, the unused
// op code and the clamped table sizes with a full table. Random phases at
// many table sizes then drive a pool of reused names in bursts. Every
// command beat is predicted on acceptance and compared with the result beat.
// ----------------------------------------------------------------------------
module double_hash_name_table_tb;

    import dhnt_pkg::*;

    // Unused op code: the block must answer with a failure and change nothing
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Slowest command: both modulo passes plus a probe of every slot
    localparam int DRAIN_CYCLES = 2 * KEY_W + 3 + TABLE_DEPTH;
    // Longest quiet spell allowed: several times the longest gap plus latency
    localparam int QUIET_LIMIT  = 3000;
    localparam int POOL_DEPTH   = 40;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [NAME_W-1:0] name_bytes;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              done;
    logic              success;
    logic [SLOT_W-1:0] slot_index;

    // Shadow copy of the table and its size register
    slot_status_t      slot_state [TABLE_DEPTH];
    logic [NAME_W-1:0] slot_names [TABLE_DEPTH];
    logic [CFG_W-1:0]  size_reg;

    // Outcomes of accepted beats, oldest first
    outcome_t          pending_outcomes [$];
    outcome_t          oldest;

    // Names already used, so that searches and removes mostly hit
    logic [NAME_W-1:0] name_pool [$];

    int                faults          = 0;
    int                results_checked = 0;
    int                beats_sent      = 0;
    int                quiet_cycles    = 0;
    int                burst_left      = 0;
    int                sizes_visited   = 0;
    int                op_tally [4]    = '{0, 0, 0, 0};

    double_hash_name_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .name_bytes  (name_bytes),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .success     (success),
        .slot_index  (slot_index)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow table: apply one command and return the outcome it must give.
    // The name is cut at its first zero byte, and the key is the byte sum of
    // what is left. Insert takes the first slot not in use; search and remove
    // skip tombstones and stop at the first empty slot.
    // ------------------------------------------------------------------------
    function automatic outcome_t table_op_outcome(input logic [OP_W-1:0]   op_code,
                                                  input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] name;
        int unsigned       key;
        int unsigned       m;
        int unsigned       home;
        int unsigned       stride;
        int unsigned       slot;
        int unsigned       i;
        int                b;
        bit                stop;
        outcome_t          res;
        name = '0;
        key  = 0;
        stop = 1'b0;
        res  = '0;
        for (b = 0; b < NAME_BYTES && !stop; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                stop = 1'b1;
            else
            begin
                key               += raw[8*b +: 8];
                name[8*b +: 8]     = raw[8*b +: 8];
            end
        end
        // Clamp the size register to the usable range
        if (size_reg < 2)
            m = 2;
        else if (size_reg > TABLE_DEPTH)
            m = TABLE_DEPTH;
        else
            m = size_reg;
        home   = key % m;
        stride = 1 + key % (m - 1);
        stop   = 1'b0;
        for (i = 0; i < m && !stop; i++)
        begin
            slot = (home + i * stride) % m;
            case (op_code)
                OP_INSERT:
                    if (slot_state[slot] != SLOT_USED)
                    begin
                        slot_state[slot] = SLOT_USED;
                        slot_names[slot] = name;
                        res.ok           = 1'b1;
                        res.slot         = SLOT_W'(slot);
                        stop             = 1'b1;
                    end
                OP_SEARCH, OP_REMOVE:
                    if (slot_state[slot] == SLOT_USED && slot_names[slot] == name)
                    begin
                        res.ok   = 1'b1;
                        res.slot = SLOT_W'(slot);
                        stop     = 1'b1;
                        if (op_code == OP_REMOVE)
                            slot_state[slot] = SLOT_GONE;
                    end
                    else if (slot_state[slot] == SLOT_EMPTY)
                        stop = 1'b1;
                default:
                    stop = 1'b1;
            endcase
        end
        return res;
    endfunction

    // A new name of random length; most use a four-letter alphabet so that
    // equal names and anagrams (same key, different name) turn up often
    function automatic logic [NAME_W-1:0] fresh_name();
        logic [NAME_W-1:0] n;
        int                b;
        int                len;
        bit                narrow;
        n      = '0;
        len    = $urandom_range(0, NAME_BYTES);
        narrow = ($urandom_range(0, 9) < 6);
        for (b = 0; b < len; b++)
            n[8*b +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 3))
                                 : 8'($urandom_range(1, 255));
        return n;
    endfunction

    // Fill the bytes past the terminating zero with rubbish; the block must
    // ignore them
    function automatic logic [NAME_W-1:0] with_tail(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] res;
        int                b;
        bit                past;
        res  = name;
        past = 1'b0;
        for (b = 0; b < NAME_BYTES; b++)
        begin
            if (past)
                res[8*b +: 8] = 8'($urandom_range(0, 255));
            else if (name[8*b +: 8] == 8'h00)
                past = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat handling. Every task starts and ends just after a rising edge.
    // start stays high from one beat to the next unless a gap drops it.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [OP_W-1:0] op_code, input logic [NAME_W-1:0] raw);
        start      <= 1'b1;
        op         <= op_code;
        name_bytes <= raw;
        // busy only moves on rising edges, so its value at the falling edge
        // is the one the next rising edge sees
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        pending_outcomes.push_back(table_op_outcome(op_code, raw));
        op_tally[op_code]++;
        beats_sent++;
    endtask

    // Drop start for the given number of cycles
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic settle();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg     = value;
        sizes_visited++;
    endtask

    // ------------------------------------------------------------------------
    // Result check: sample at the falling edge, where the result is stable.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            results_checked++;
            if (pending_outcomes.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("MISMATCH: result beat with nothing outstanding (success %0b slot %0d)",
                             success, slot_index);
            end
            else
            begin
                oldest = pending_outcomes.pop_front();
                if (success !== oldest.ok || slot_index !== oldest.slot)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("MISMATCH result %0d: success exp %0b got %0b, slot exp %0d got %0d",
                                 results_checked, oldest.ok, success, oldest.slot, slot_index);
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves either way
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_outcomes.size());
                $display("[double_hash_name_table] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed: table at its reset size, colliding names and tombstones
    // ------------------------------------------------------------------------
    task automatic test_reset_size_and_collisions();
        send_beat(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);   // largest key
        send_beat(OP_INSERT, 64'h0);                      // empty name, key zero
        send_beat(OP_INSERT, 64'h0000_0000_4300_4241);   // "AB" with rubbish after the zero
        send_beat(OP_SEARCH, 64'h0000_0000_0000_4241);   // same name without the tail
        send_beat(OP_INSERT, 64'h0000_0000_0000_4142);   // anagram: same key, must probe on
        send_beat(OP_SEARCH, 64'h0000_0000_0000_4142);
        send_beat(OP_REMOVE, 64'h0000_0000_0000_4241);   // leave a tombstone
        send_beat(OP_SEARCH, 64'h0000_0000_0000_4142);   // search must step over it
        send_beat(OP_SEARCH, 64'h0000_0000_0000_4241);   // gone now
        send_beat(OP_REMOVE, 64'h0000_0000_0000_4241);   // remove of an absent name
        send_beat(OP_INSERT, 64'h0000_0000_0000_4241);   // reuses the tombstone
        send_beat(OP_INSERT, 64'h0000_0000_0000_4241);   // no duplicate check
        send_beat(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(OP_REMOVE, 64'h0);
        send_beat(OP_SEARCH, 64'h0);
        send_beat(OP_INSERT, 64'h8000_0000_0000_0001);   // top byte lies past a zero
        send_beat(OP_SEARCH, 64'h0000_0000_0000_0001);
    endtask

    // ------------------------------------------------------------------------
    // Directed: size register below and above range, full table
    // ------------------------------------------------------------------------
    task automatic test_size_limits_and_full();
        write_table_size(8'd0);                          // behaves as two slots
        send_beat(OP_INSERT, 64'h78);
        send_beat(OP_INSERT, 64'h79);
        send_beat(OP_INSERT, 64'h7A);                     // may find the table full
        send_beat(OP_SEARCH, 64'h79);
        send_beat(OP_REMOVE, 64'h71);
        write_table_size(8'd1);                          // also two slots
        send_beat(OP_INSERT, 64'h77);
        send_beat(OP_SEARCH, 64'h78);
        write_table_size(8'd255);                        // behaves as the full depth
        send_beat(OP_SEARCH, 64'h78);                     // old entries stay where they were
        send_beat(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic at one table size, in bursts unless steady is set
    // ------------------------------------------------------------------------
    task automatic run_name_traffic(input int beats, input bit steady);
        int                n;
        int                r;
        logic [OP_W-1:0]   op_code;
        logic [NAME_W-1:0] raw;
        for (n = 0; n < beats; n++)
        begin
            if (!steady)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    r          = $urandom_range(0, 99);
                    // Short gaps land inside the block's work, long ones after it
                    if (r < 70)
                        hold_off($urandom_range(1, 4));
                    else if (r < 95)
                        hold_off($urandom_range(5, 40));
                    else
                        hold_off($urandom_range(100, 220));
                end
                burst_left--;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                op_code = OP_UNUSED;
                raw     = {$urandom, $urandom};
            end
            else
            begin
                if (r < 43)
                    op_code = OP_INSERT;
                else if (r < 78)
                    op_code = OP_SEARCH;
                else
                    op_code = OP_REMOVE;
                // Reuse a known name most of the time
                if (name_pool.size() != 0 &&
                    $urandom_range(0, 99) < ((op_code == OP_INSERT) ? 50 : 85))
                    raw = name_pool[$urandom_range(0, name_pool.size() - 1)];
                else
                begin
                    raw = fresh_name();
                    if (name_pool.size() < POOL_DEPTH)
                        name_pool.push_back(raw);
                    else
                        name_pool[$urandom_range(0, POOL_DEPTH - 1)] = raw;
                end
                r = $urandom_range(0, 99);
                if (r < 5)
                    raw = {$urandom, $urandom};          // noise over all 64 bits
                else if (r < 20)
                    raw = with_tail(raw);
            end
            send_beat(op_code, raw);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] phase_sizes [12];
        int               p;
        phase_sizes = '{8'd127, 8'd3, 8'd128, 8'd2, 8'd17, 8'd64,
                        8'd1, 8'd200, 8'd5, 8'd100, 8'd0, 8'd31};
        for (p = 0; p < 12; p++)
        begin
            write_table_size(phase_sizes[p]);
            // Every fourth phase runs without gaps
            run_name_traffic(160, (p % 4) == 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int s;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_INSERT;
        name_bytes  = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        size_reg    = TABLE_SIZE_RST;
        for (s = 0; s < TABLE_DEPTH; s++)
        begin
            slot_state[s] = SLOT_EMPTY;
            slot_names[s] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size_and_collisions();
        test_size_limits_and_full();
        test_random_traffic();

        // Drain, then hold for one slowest command to catch stray results
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d commands: %0d insert, %0d search, %0d remove, %0d unused code",
                 beats_sent, op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
        $display("Table size written %0d times; %0d results compared, %0d mismatches",
                 sizes_visited, results_checked, faults);
        if (faults == 0 && pending_outcomes.size() == 0)
            $display("[double_hash_name_table] OK");
        else
            $display("[double_hash_name_table] ERROR");
        $finish;
    end

endmodule
